@@ hdl/llmf_pkg.sv @@
package llmf_pkg;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IDX_W     = 11;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic found;
    idx_t row_index;
    idx_t col_index;
  } result_t;

endpackage

@@ hdl/llmf_if.sv @@
interface llmf_sample_if #(
  parameter int unsigned DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface llmf_result_if;
  import llmf_pkg::*;

  logic valid;
  logic ready;
  logic found;
  idx_t row_index;
  idx_t col_index;

  modport source (output valid, output found, output row_index, output col_index, input ready);
  modport sink (input valid, input found, input row_index, input col_index, output ready);
endinterface

@@ hdl/llmf_line_store.sv @@
module llmf_line_store #(
  parameter int unsigned DW    = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  logic [2*DW-1:0] wr_data_i,
  output logic [2*DW-1:0] rd_data_o
);

  logic [2*DW-1:0] mem [DEPTH];
  logic [2*DW-1:0] ram_q;
  logic [2*DW-1:0] byp_q;
  logic            byp_sel_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      ram_q <= mem[rd_addr_i];
      byp_q <= wr_data_i;
    end
  end

  // Read and write of the same entry at one edge: take the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_sel_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_sel_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_sel_q ? byp_q : ram_q;

endmodule

@@ hdl/last_local_minimum_finder.sv @@
// res_o.valid is high while the result queue, filled from the judge stage, is not empty.
// Throughput: one sample per cycle; each sample does one read-modify-write of the line store
// entry of its column. The input stalls only while queued results plus a sample in the judge
// stage reach four.
// Reset: frame size 1x1, position and last minimum cleared, result queue empty.
// Line store contents are left as they are; every entry is written before its value is used.
module last_local_minimum_finder #(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned MAX_ROWS   = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [llmf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [llmf_pkg::CFG_W-1:0]     cfg_data_i,
  llmf_sample_if.sink                    smp_i,
  llmf_result_if.source                  res_o
);
  import llmf_pkg::*;

  localparam int unsigned CW         = $clog2(MAX_COLS);
  localparam int unsigned RW         = $clog2(MAX_ROWS);
  localparam int unsigned DW         = DATA_WIDTH;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic c_ge1;
    logic c_ge2;
    logic r_ge1;
    logic r_ge2;
    logic last_col;
    logic last_row;
  } pos_t;

  function automatic logic [31:0] dim_m1(logic [CFG_W-1:0] v, int unsigned maxv);
    if (v == '0) return 32'd0;
    if (32'(v) > maxv) return maxv - 1;
    return 32'(v) - 32'd1;
  endfunction

  function automatic logic is_min(
    logic signed [DW-1:0] self,
    logic signed [DW-1:0] lft, logic has_l,
    logic signed [DW-1:0] rgt, logic has_r,
    logic signed [DW-1:0] up,  logic has_u,
    logic signed [DW-1:0] dn,  logic has_d
  );
    return (!has_l || self < lft) && (!has_r || self < rgt) &&
           (!has_u || self < up) && (!has_d || self < dn);
  endfunction

  // Configuration, kept as size minus one
  logic [RW-1:0] rows_m1_q;
  logic [CW-1:0] cols_m1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m1_q <= '0;
      cols_m1_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_ROWS: rows_m1_q <= RW'(dim_m1(cfg_data_i, MAX_ROWS));
        REG_NUM_COLS: cols_m1_q <= CW'(dim_m1(cfg_data_i, MAX_COLS));
      endcase
    end
  end

  // Input side
  logic          accept;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  pos_t          pos_d;

  logic             s1_valid_q;
  logic [CNT_W-1:0] cnt_q;

  assign smp_i.ready = (cnt_q + CNT_W'(s1_valid_q)) < CNT_W'(FIFO_DEPTH);
  assign accept      = smp_i.valid && smp_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_we_i) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      if (col_q == cols_m1_q) begin
        col_q <= '0;
        row_q <= (row_q == rows_m1_q) ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  always_comb begin
    pos_d.c_ge1    = col_q != '0;
    pos_d.c_ge2    = col_q > CW'(1);
    pos_d.r_ge1    = row_q != '0;
    pos_d.r_ge2    = row_q > RW'(1);
    pos_d.last_col = col_q == cols_m1_q;
    pos_d.last_row = row_q == rows_m1_q;
  end

  // Stage 1: line store word is back, judge and write back
  logic signed [DW-1:0] s1_s_q;
  logic [RW-1:0]        s1_r_q;
  logic [CW-1:0]        s1_c_q;
  pos_t                 s1_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_s_q   <= smp_i.sample;
      s1_r_q   <= row_q;
      s1_c_q   <= col_q;
      s1_pos_q <= pos_d;
    end
  end

  logic [2*DW-1:0]      rd_word;
  logic signed [DW-1:0] ctr;
  logic signed [DW-1:0] upr;

  llmf_line_store #(
    .DW    (DW),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_c_q),
    .wr_data_i ({s1_s_q, ctr}),
    .rd_data_o (rd_word)
  );

  assign ctr = rd_word[2*DW-1:DW];
  assign upr = rd_word[DW-1:0];

  // Window over the previous two samples of this row and the line above
  logic signed [DW-1:0] w_ctr_q;
  logic signed [DW-1:0] w_ctr2_q;
  logic signed [DW-1:0] w_up_q;
  logic signed [DW-1:0] w_dn_q;
  logic signed [DW-1:0] w_s2_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      w_ctr_q  <= ctr;
      w_ctr2_q <= w_ctr_q;
      w_up_q   <= upr;
      w_dn_q   <= s1_s_q;
      w_s2_q   <= w_dn_q;
    end
  end

  logic p_ok, q_ok, lp_ok, lq_ok;

  // Upper row: element left of this column, and this column at row end
  assign p_ok = s1_pos_q.r_ge1 && s1_pos_q.c_ge1 &&
                is_min(w_ctr_q, w_ctr2_q, s1_pos_q.c_ge2, ctr, 1'b1,
                       w_up_q, s1_pos_q.r_ge2, w_dn_q, 1'b1);
  assign q_ok = s1_pos_q.r_ge1 && s1_pos_q.last_col &&
                is_min(ctr, w_ctr_q, s1_pos_q.c_ge1, ctr, 1'b0,
                       upr, s1_pos_q.r_ge2, s1_s_q, 1'b1);
  // Last row has no lower neighbor
  assign lp_ok = s1_pos_q.last_row && s1_pos_q.c_ge1 &&
                 is_min(w_dn_q, w_s2_q, s1_pos_q.c_ge2, s1_s_q, 1'b1,
                        w_ctr_q, s1_pos_q.r_ge1, s1_s_q, 1'b0);
  assign lq_ok = s1_pos_q.last_row && s1_pos_q.last_col &&
                 is_min(s1_s_q, w_dn_q, s1_pos_q.c_ge1, s1_s_q, 1'b0,
                        ctr, s1_pos_q.r_ge1, s1_s_q, 1'b0);

  // Last minimum above the last row, and within the last row
  logic          in_f_q, in_f_d;
  logic [RW-1:0] in_r_q, in_r_d;
  logic [CW-1:0] in_c_q, in_c_d;
  logic          lt_f_q, lt_f_d;
  logic [RW-1:0] lt_r_q, lt_r_d;
  logic [CW-1:0] lt_c_q, lt_c_d;
  logic          push;
  result_t       res_d;

  always_comb begin
    in_f_d = in_f_q;
    in_r_d = in_r_q;
    in_c_d = in_c_q;
    lt_f_d = lt_f_q;
    lt_r_d = lt_r_q;
    lt_c_d = lt_c_q;
    if (q_ok) begin
      in_f_d = 1'b1;
      in_r_d = s1_r_q - RW'(1);
      in_c_d = s1_c_q;
    end else if (p_ok) begin
      in_f_d = 1'b1;
      in_r_d = s1_r_q - RW'(1);
      in_c_d = s1_c_q - CW'(1);
    end
    if (lq_ok) begin
      lt_f_d = 1'b1;
      lt_r_d = s1_r_q;
      lt_c_d = s1_c_q;
    end else if (lp_ok) begin
      lt_f_d = 1'b1;
      lt_r_d = s1_r_q;
      lt_c_d = s1_c_q - CW'(1);
    end
    res_d.found     = lt_f_d || in_f_d;
    res_d.row_index = '0;
    res_d.col_index = '0;
    if (lt_f_d) begin
      res_d.row_index = IDX_W'(32'(lt_r_d) + 32'd1);
      res_d.col_index = IDX_W'(32'(lt_c_d) + 32'd1);
    end else if (in_f_d) begin
      res_d.row_index = IDX_W'(32'(in_r_d) + 32'd1);
      res_d.col_index = IDX_W'(32'(in_c_d) + 32'd1);
    end
  end

  assign push = s1_valid_q && s1_pos_q.last_row && s1_pos_q.last_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_f_q <= 1'b0;
      in_r_q <= '0;
      in_c_q <= '0;
      lt_f_q <= 1'b0;
      lt_r_q <= '0;
      lt_c_q <= '0;
    end else if (cfg_we_i || push) begin
      in_f_q <= 1'b0;
      in_r_q <= '0;
      in_c_q <= '0;
      lt_f_q <= 1'b0;
      lt_r_q <= '0;
      lt_c_q <= '0;
    end else if (s1_valid_q) begin
      in_f_q <= in_f_d;
      in_r_q <= in_r_d;
      in_c_q <= in_c_d;
      lt_f_q <= lt_f_d;
      lt_r_q <= lt_r_d;
      lt_c_q <= lt_c_d;
    end
  end

  // Result queue: holds frames whose result has not been transferred yet
  result_t          fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic             pop;

  assign pop = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign res_o.valid     = cnt_q != '0;
  assign res_o.found     = fifo_q[rd_ptr_q].found;
  assign res_o.row_index = fifo_q[rd_ptr_q].row_index;
  assign res_o.col_index = fifo_q[rd_ptr_q].col_index;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import llmf_pkg::*;

  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned DATA_W  = 32;

  typedef enum int {VAL_NARROW, VAL_WIDE, VAL_EDGE} value_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  llmf_sample_if #(.DATA_WIDTH(DATA_W)) smp_if ();
  llmf_result_if                        res_if ();

  last_local_minimum_finder #(
    .MAX_COLS  (MAX_DIM),
    .MAX_ROWS  (MAX_DIM),
    .DATA_WIDTH(DATA_W)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .smp_i     (smp_if),
    .res_o     (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Local copy of the frame scanner state
  logic [CFG_W-1:0]   num_rows_reg = 1;
  logic [CFG_W-1:0]   num_cols_reg = 1;
  logic signed [DATA_W-1:0] upper_row  [0:MAX_DIM-1];
  logic signed [DATA_W-1:0] center_row [0:MAX_DIM-1];
  logic signed [DATA_W-1:0] left_val;
  int unsigned        at_row, at_col;
  bit                 best_found;
  int unsigned        best_r, best_c;

  logic signed [DATA_W-1:0] sample_q [$];
  result_t            minimum_q [$];
  int                 error_count;
  int                 samples_sent;

  // Sender and receiver idling controls
  bit                 send_gaps;
  bit                 recv_stalls;
  int                 gap_left, burst_left;
  int                 hold_left;
  int                 run_left;
  bit                 run_on;

  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic void restart_position();
    at_row     = 0;
    at_col     = 0;
    best_found = 1'b0;
    best_r     = 0;
    best_c     = 0;
  endfunction

  function automatic void mark_if_minimum(input int unsigned r, input int unsigned c,
                                          input logic signed [DATA_W-1:0] self,
                                          input bit has_l, input logic signed [DATA_W-1:0] l,
                                          input bit has_r, input logic signed [DATA_W-1:0] rt,
                                          input bit has_u, input logic signed [DATA_W-1:0] u,
                                          input bit has_d, input logic signed [DATA_W-1:0] d);
    bit is_min;
    is_min = 1'b1;
    if (has_l && !(self < l)) is_min = 1'b0;
    if (has_r && !(self < rt)) is_min = 1'b0;
    if (has_u && !(self < u)) is_min = 1'b0;
    if (has_d && !(self < d)) is_min = 1'b0;
    if (is_min) begin
      best_found = 1'b1;
      best_r     = r;
      best_c     = c;
    end
  endfunction

  // Advance the scan by one sample; element (r-1, c) is settled once its lower neighbor arrives
  function automatic void track_sample(input logic signed [DATA_W-1:0] s);
    int unsigned rows, cols, r, c, k;
    result_t     res;
    rows = eff_dim(num_rows_reg);
    cols = eff_dim(num_cols_reg);
    r    = at_row;
    c    = at_col;
    if (r >= rows || c >= cols) begin
      r = 0;
      c = 0;
    end
    if (r >= 1) begin
      mark_if_minimum(r - 1, c, center_row[c], c > 0, left_val,
                      c + 1 < cols, (c + 1 < cols) ? center_row[c + 1] : '0,
                      r >= 2, upper_row[c], 1'b1, s);
      left_val     = center_row[c];
      upper_row[c] = center_row[c];
    end
    center_row[c] = s;
    if (c + 1 < cols) begin
      at_row = r;
      at_col = c + 1;
    end else if (r + 1 < rows) begin
      at_row = r + 1;
      at_col = 0;
    end else begin
      // Last row has no lower neighbor
      for (k = 0; k < cols; k++) begin
        mark_if_minimum(r, k, center_row[k], k > 0, (k > 0) ? center_row[k - 1] : '0,
                        k + 1 < cols, (k + 1 < cols) ? center_row[k + 1] : '0,
                        r >= 1, upper_row[k], 1'b0, '0);
      end
      res.found     = best_found;
      res.row_index = best_found ? idx_t'(best_r + 1) : '0;
      res.col_index = best_found ? idx_t'(best_c + 1) : '0;
      minimum_q.push_back(res);
      restart_position();
    end
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    error_count++;
    if (error_count <= 100)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want_v, got_v);
  endtask

  // Sample driver: bursts with random gaps when send_gaps is set; valid holds until the transfer
  always @(posedge clk_i) begin
    if (rst_ni && smp_if.valid && smp_if.ready) begin
      track_sample(sample_q.pop_front());
      if (burst_left > 0) burst_left--;
    end
    if (gap_left == 0 && burst_left == 0 && sample_q.size() != 0) begin
      burst_left = $urandom_range(1, 24);
      if (send_gaps) gap_left = $urandom_range(1, 8);
    end
    if (gap_left > 0 || sample_q.size() == 0) begin
      if (gap_left > 0) gap_left--;
      smp_if.valid <= 1'b0;
    end else begin
      smp_if.valid  <= 1'b1;
      smp_if.sample <= sample_q[0];
    end
  end

  // Result receiver: long hold when requested, else on/off stalls with recv_stalls, else ready
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (!recv_stalls) begin
      res_if.ready <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_on   = !run_on;
        run_left = run_on ? $urandom_range(1, 6) : $urandom_range(1, 5);
      end
      run_left--;
      res_if.ready <= run_on;
    end
  end

  always @(posedge clk_i) begin : check_minimum
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (minimum_q.size() == 0) begin
        report_mismatch("unexpected result, found", 0, res_if.found);
      end else begin
        want = minimum_q.pop_front();
        if (res_if.found !== want.found)
          report_mismatch("found", want.found, res_if.found);
        if (res_if.row_index !== want.row_index)
          report_mismatch("row_index", want.row_index, res_if.row_index);
        if (res_if.col_index !== want.col_index)
          report_mismatch("col_index", want.col_index, res_if.col_index);
      end
    end
  end

  task automatic send_sample(input logic signed [DATA_W-1:0] v);
    while (sample_q.size() >= 8) @(posedge clk_i);
    sample_q.push_back(v);
    samples_sent++;
  endtask

  // Let queued samples and pending results drain, then allow the pipeline to settle
  task automatic wait_idle();
    do @(posedge clk_i); while (sample_q.size() != 0 || minimum_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == REG_NUM_ROWS) num_rows_reg = value;
    else num_cols_reg = value;
    restart_position();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_frame_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    wait_idle();
    write_register(REG_NUM_ROWS, rows);
    write_register(REG_NUM_COLS, cols);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(input value_mode_e mode);
    case (mode)
      VAL_NARROW: return $urandom_range(0, 4) - 2;
      VAL_WIDE:   return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return $urandom;
          default: return $urandom_range(0, 6) - 3;
        endcase
      end
    endcase
  endfunction

  task automatic send_frame(input int unsigned count, input value_mode_e mode);
    repeat (count) send_sample(pick_value(mode));
  endtask

  // Zero sizes act as one: a single element is always a minimum
  task automatic test_single_element();
    set_frame_size(0, 0);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
  endtask

  task automatic test_ties_and_edges();
    set_frame_size(2, 2);
    repeat (4) send_sample(32'sd5);
    set_frame_size(2, 3);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh8000_0000);
    send_sample(32'sd0);
    send_sample(32'sh8000_0000);
    send_sample(32'sd5);
    send_sample(32'sd5);
    set_frame_size(3, 1);
    send_sample(32'sd3);
    send_sample(-32'sd1);
    send_sample(32'sd2);
    set_frame_size(1, 3);
    send_sample(32'sd4);
    send_sample(32'sd4);
    send_sample(-32'sd7);
  endtask

  // A register write in the middle of a frame drops the partial frame
  task automatic test_restart();
    set_frame_size(3, 3);
    repeat (4) send_sample(-32'sd100);
    wait_idle();
    write_register(REG_NUM_COLS, 3);
    repeat (4) send_sample(32'sd5);
    send_sample(-32'sd9);
    repeat (4) send_sample(32'sd5);
  endtask

  task automatic test_backpressure();
    set_frame_size(1, 1);
    send_gaps = 1'b0;
    hold_left = 400;
    send_frame(40, VAL_WIDE);
    wait_idle();
  endtask

  task automatic test_large_frames();
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    set_frame_size(100, 1);
    send_frame(100, VAL_NARROW);
    set_frame_size(2, 100);
    send_frame(200, VAL_NARROW);
  endtask

  task automatic test_random();
    int unsigned rows, cols, frames, partial;
    while (samples_sent < 800) begin
      rows = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
      cols = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      send_gaps   = $urandom_range(0, 3) != 0;
      recv_stalls = $urandom_range(0, 2) != 0;
      set_frame_size(CFG_W'((rows == 1 && $urandom_range(0, 1)) ? 0 : rows),
                     CFG_W'((cols == 1 && $urandom_range(0, 1)) ? 0 : cols));
      frames = $urandom_range(1, 4);
      repeat (frames) send_frame(rows * cols, value_mode_e'($urandom_range(0, 2)));
      // Leave a frame unfinished now and then; the next size write restarts it
      if (rows * cols > 1 && $urandom_range(0, 7) == 0) begin
        partial = $urandom_range(1, rows * cols - 1);
        send_frame(partial, value_mode_e'($urandom_range(0, 2)));
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("[last_local_minimum_finder] ERROR");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_NUM_ROWS;
    cfg_data_i   = '0;
    smp_if.valid = 1'b0;
    smp_if.sample = '0;
    res_if.ready = 1'b0;
    error_count  = 0;
    samples_sent = 0;
    send_gaps    = 1'b0;
    recv_stalls  = 1'b0;
    gap_left     = 0;
    burst_left   = 0;
    hold_left    = 0;
    run_left     = 0;
    run_on       = 1'b0;
    left_val     = '0;
    restart_position();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_single_element();
    test_ties_and_edges();
    test_restart();
    test_backpressure();
    test_large_frames();
    test_random();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && minimum_q.size() == 0) begin
      $display("[last_local_minimum_finder] OK");
    end else begin
      $display("[last_local_minimum_finder] ERROR");
    end
    $finish;
  end

endmodule

@@ last_local_minimum_finder.f @@
hdl/llmf_pkg.sv
hdl/llmf_if.sv
hdl/llmf_line_store.sv
hdl/last_local_minimum_finder.sv
sim/testbench.sv
